// ===== rtl/svm_pkg.sv =====
// ============================================================================
// svm_pkg
// shared types, constants and widths of the sample-playback voice mixer
// ============================================================================
package svm_pkg;

    // block configuration (sample memory depth is a power of two)
    localparam int VOICE_COUNT  = 8;
    localparam int SAMPLE_WORDS = 16384;
    localparam int SAMPLE_BITS  = 16;

    // fixed beat field widths
    localparam int KIND_W  = 2;
    localparam int WADDR_W = 14;
    localparam int SMP_W   = 16;
    localparam int START_W = 14;
    localparam int LEN_W   = 15;
    localparam int VOL_W   = 9;

    // input tdata layout, lowest field first
    localparam int WADDR_LSB   = 0;
    localparam int SMP_LSB     = WADDR_LSB + WADDR_W;
    localparam int START_LSB   = SMP_LSB + SMP_W;
    localparam int LEN_LSB     = START_LSB + START_W;
    localparam int VOL_LSB     = LEN_LSB + LEN_W;
    localparam int IN_FIELDS_W = VOL_LSB + VOL_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // derived widths
    localparam int ADDR_W  = $clog2(SAMPLE_WORDS);
    localparam int POS_W   = $clog2(SAMPLE_WORDS + 1);
    localparam int VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W   = $clog2(VOICE_COUNT + 2);
    localparam int PROD_W  = VOL_W + 1 + SMP_W;
    localparam int ACC_W   = PROD_W + VIDX_W;
    localparam int GAIN_SHIFT = 8;
    localparam int RAW_W   = (ACC_W - GAIN_SHIFT > SAMPLE_BITS + 1) ?
                             (ACC_W - GAIN_SHIFT) : (SAMPLE_BITS + 2);
    localparam int NUM_W   = RAW_W + SAMPLE_BITS - 1;
    localparam int DEN_W   = RAW_W + 4;
    // soft clip quotient stays below full scale / 10
    localparam int QUO_W   = SAMPLE_BITS - 4;

    localparam int UNITY_GAIN = 256;
    localparam int FULL_SCALE = 1 << (SAMPLE_BITS - 1);
    localparam int OUT_MAX    = 32767;
    localparam int OUT_MIN    = -32768;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_START   = 2'd1,
        KIND_PRODUCE = 2'd2
    } svm_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_COMMIT,
        ST_MIX,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } svm_state_t;

    typedef struct packed {
        logic              load;
        logic              mem_wr;
        logic              scan_step;
        logic              commit;
        logic              mix_issue;
        logic              div_start;
        logic              out_load;
        logic              out_mute;
        logic [VIDX_W-1:0] vidx;
    } svm_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic cur_busy;
        logic div_busy;
    } svm_sts_t;

endpackage

// ===== rtl/svm_ram.sv =====
// ============================================================================
// svm_ram
// generic single write port, single read port ram with registered read
// ============================================================================
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/svm_div.sv =====
// ============================================================================
// svm_div
// restoring divider for the soft clip, one quotient bit per cycle
// ============================================================================
module svm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [svm_pkg::NUM_W-1:0]  num,
    input  logic [svm_pkg::DEN_W-1:0]  den,
    output logic                       busy,
    output logic [svm_pkg::QUO_W-1:0]  quo
);
    import svm_pkg::*;

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              ge;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        ge        = (rem_reg >= dsh_reg);
        if (start)
        begin
            // divisor aligned to the top quotient bit
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (QUO_W - 1);
            quo_next  = '0;
            step_next = STEP_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next  = dsh_reg >> 1;
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            busy_next = (step_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/svm_dp.sv =====
// ============================================================================
// svm_dp
// mixer datapath: voice registers, sample memory, mac pipe and soft clip
// ============================================================================
module svm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  svm_pkg::svm_cmd_t             cmd,
    output svm_pkg::svm_sts_t             sts,
    input  logic [svm_pkg::IN_DATA_W-1:0] in_data,
    output logic [svm_pkg::SMP_W-1:0]     out_sample,
    output logic                          out_clip
);
    import svm_pkg::*;

    // latched beat fields
    logic [WADDR_W-1:0] waddr_reg;
    logic [SMP_W-1:0]   wdata_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [VOL_W-1:0]   vol_reg;

    // voice state
    logic              busy_reg [VOICE_COUNT];
    logic [ADDR_W-1:0] base_reg [VOICE_COUNT];
    logic [POS_W-1:0]  pos_reg  [VOICE_COUNT];
    logic [POS_W-1:0]  span_reg [VOICE_COUNT];
    logic [VOL_W-1:0]  gain_reg [VOICE_COUNT];

    // steal search
    logic [POS_W-1:0]  best_reg;
    logic [VIDX_W-1:0] slot_reg;

    // mac pipe
    logic                     s1_valid_reg;
    logic [VOL_W-1:0]         s1_gain_reg;
    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // soft clip
    logic                    pos_clip_reg, neg_clip_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic [SMP_W-1:0]        out_sample_reg;
    logic                    out_clip_reg;

    logic [ADDR_W-1:0]        rd_addr;
    logic [SMP_W-1:0]         rd_data;
    logic signed [VOL_W:0]    gain_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_sh;
    logic signed [RAW_W-1:0]  raw;
    logic [RAW_W-1:0]         mag;
    logic [NUM_W-1:0]         num;
    logic [DEN_W-1:0]         den;
    logic                     div_busy;
    logic [QUO_W-1:0]         quo;
    logic signed [RAW_W-1:0]  y_pos;
    logic signed [RAW_W-1:0]  y;
    logic signed [RAW_W-1:0]  y_sat;
    logic [POS_W-1:0]         span_sat;
    logic [VOL_W-1:0]         gain_sat;
    logic [POS_W-1:0]         pos_inc;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [WADDR_W-1:0] a);
        logic [WADDR_W+ADDR_W-1:0] w;
        w = {{ADDR_W{1'b0}}, a};
        return w[ADDR_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            waddr_reg <= in_data[WADDR_LSB +: WADDR_W];
            wdata_reg <= in_data[SMP_LSB +: SMP_W];
            start_reg <= in_data[START_LSB +: START_W];
            len_reg   <= in_data[LEN_LSB +: LEN_W];
            vol_reg   <= in_data[VOL_LSB +: VOL_W];
        end
    end

    // start saturation, and the next play position of the current voice
    always_comb
    begin
        span_sat = (32'(len_reg) > 32'(SAMPLE_WORDS)) ? POS_W'(SAMPLE_WORDS)
                                                      : POS_W'(len_reg);
        gain_sat = (32'(vol_reg) > 32'(UNITY_GAIN)) ? VOL_W'(UNITY_GAIN) : vol_reg;
        pos_inc  = pos_reg[cmd.vidx] + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                busy_reg[i] <= 1'b0;
                base_reg[i] <= '0;
                pos_reg[i]  <= '0;
                span_reg[i] <= '0;
                gain_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            busy_reg[slot_reg] <= 1'b1;
            base_reg[slot_reg] <= wrap_addr(start_reg);
            pos_reg[slot_reg]  <= '0;
            span_reg[slot_reg] <= span_sat;
            gain_reg[slot_reg] <= gain_sat;
        end
        else if (cmd.mix_issue && busy_reg[cmd.vidx])
        begin
            pos_reg[cmd.vidx] <= pos_inc;
            if (pos_inc >= span_reg[cmd.vidx])
            begin
                busy_reg[cmd.vidx] <= 1'b0;
            end
        end
    end

    // largest position wins, later index on a tie, idle voice ends the scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            best_reg <= '0;
            slot_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!busy_reg[cmd.vidx])
            begin
                slot_reg <= cmd.vidx;
            end
            else if (pos_reg[cmd.vidx] >= best_reg)
            begin
                best_reg <= pos_reg[cmd.vidx];
                slot_reg <= cmd.vidx;
            end
        end
    end

    assign rd_addr = base_reg[cmd.vidx] + pos_reg[cmd.vidx][ADDR_W-1:0];

    svm_ram #(
        .WIDTH (SMP_W),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (cmd.mem_wr),
        .wr_addr (wrap_addr(waddr_reg)),
        .wr_data (wdata_reg),
        .rd_en   (cmd.mix_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign gain_s    = signed'({1'b0, s1_gain_reg});
    assign prod_next = gain_s * signed'(rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.mix_issue & busy_reg[cmd.vidx];
            p_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_gain_reg <= gain_reg[cmd.vidx];
        prod_reg    <= prod_next;
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (p_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor divide by unity gain, then magnitude for the clip curve
    always_comb
    begin
        acc_sh = acc_reg >>> GAIN_SHIFT;
        raw    = RAW_W'(acc_sh);
        mag    = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
        num    = (NUM_W'(mag) - NUM_W'(FULL_SCALE)) << (SAMPLE_BITS - 1);
        den    = (DEN_W'(mag) << 3) + (DEN_W'(mag) << 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            raw_reg      <= raw;
            pos_clip_reg <= (raw > signed'(RAW_W'(FULL_SCALE)));
            neg_clip_reg <= (raw < -signed'(RAW_W'(FULL_SCALE)));
        end
    end

    svm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_comb
    begin
        y_pos = signed'(RAW_W'(FULL_SCALE)) - signed'(RAW_W'(quo));
        priority if (pos_clip_reg)
        begin
            y = y_pos;
        end
        else if (neg_clip_reg)
        begin
            y = -y_pos;
        end
        else
        begin
            y = raw_reg;
        end
        priority if (y > signed'(RAW_W'(OUT_MAX)))
        begin
            y_sat = signed'(RAW_W'(OUT_MAX));
        end
        else if (y < signed'(RAW_W'(OUT_MIN)))
        begin
            y_sat = signed'(RAW_W'(OUT_MIN));
        end
        else
        begin
            y_sat = y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_mute)
            begin
                out_sample_reg <= '0;
                out_clip_reg   <= 1'b0;
            end
            else
            begin
                out_sample_reg <= y_sat[SMP_W-1:0];
                out_clip_reg   <= pos_clip_reg | neg_clip_reg;
            end
        end
    end

    assign sts.len_zero = (len_reg == '0);
    assign sts.cur_busy = busy_reg[cmd.vidx];
    assign sts.div_busy = div_busy;
    assign out_sample   = out_sample_reg;
    assign out_clip     = out_clip_reg;

endmodule

// ===== rtl/svm_ctrl.sv =====
// ============================================================================
// svm_ctrl
// mixer sequencer: beat decode, voice scan, mix sweep, clip and output beat
// ============================================================================
module svm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [svm_pkg::KIND_W-1:0] kind,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    output svm_pkg::svm_cmd_t          cmd,
    input  svm_pkg::svm_sts_t          sts
);
    import svm_pkg::*;

    svm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             mute_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mute_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mute_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        cmd            = '0;
        cmd.vidx       = cnt_reg[VIDX_W-1:0];
        s_tready       = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    case (kind)
                        KIND_WRITE:   state_next = ST_WRITE;
                        KIND_START:   state_next = ST_SCAN;
                        KIND_PRODUCE: state_next = mute_reg ? ST_OUT : ST_MIX;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.len_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (!sts.cur_busy || cnt_reg == CNT_W'(VOICE_COUNT - 1))
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MIX:
            begin
                cmd.mix_issue = (cnt_reg < CNT_W'(VOICE_COUNT));
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VOICE_COUNT + 1))
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_mute   = mute_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/polyphonic_sample_voice_mixer.sv =====
// ============================================================================
// polyphonic_sample_voice_mixer
// sample playback mixer with voice stealing and a symmetric soft clip
// ============================================================================
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata fields, s_tuser kind
//  m_       out  m_tvalid/m_tready   m_tdata mixed_sample, m_tuser clipped
//  cfg_     in   cfg_wr_en           cfg_wr_data mute
//
//  write beat: a write state; start beat: a serial voice scan, ended early by an idle voice, then a commit
//  produce beat: the one-read-per-cycle sample memory sweep over the voices, then
//  the bit-serial clip divider and the output step;
//  a muted produce goes straight to its output step
//  reset clears voices, mute and control; sample memory holds garbage until written
//  a finished sample waits in the output register while the next beat is taken;
//  the next produce only stalls at its output step until that register drains
//
module polyphonic_sample_voice_mixer (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // write_address, sample_value, sound_start, sound_length, volume, zero pad
    input  logic [svm_pkg::IN_DATA_W-1:0] s_tdata,
    // kind
    input  logic [svm_pkg::KIND_W-1:0]    s_tuser,
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // mixed_sample
    output logic [svm_pkg::SMP_W-1:0]     m_tdata,
    // clipped
    output logic                          m_tuser,
    // mute register
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);
    import svm_pkg::*;

    svm_cmd_t cmd;
    svm_sts_t sts;

    // sequencer: owns the handshakes, mute and the voice / sweep counter
    svm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .kind        (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    // datapath: voice file, sample ram, mac pipe, divider, output register
    svm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (s_tdata),
        .out_sample (m_tdata),
        .out_clip   (m_tuser)
    );

endmodule

// ===== tb/sv/tb_polyphonic_sample_voice_mixer.sv =====
// ============================================================================
// tb_polyphonic_sample_voice_mixer
// self-checking bench for the sample playback mixer: a cycle-free model of the
// voices, sample memory and soft clip predicts every mixed sample, and each
// output beat is compared field by field under random idling and back pressure
// ============================================================================
module tb_polyphonic_sample_voice_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import svm_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    // longest beat is a produce; a start always ends sooner
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 800_000;
    localparam int HOT_WORDS     = 256;

    // kind code the block drops without a result
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    // one input beat, unpacked into its fields
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [WADDR_W-1:0] waddr;
        logic [SMP_W-1:0]   value;
        logic [START_W-1:0] sound_start;
        logic [LEN_W-1:0]   sound_len;
        logic [VOL_W-1:0]   volume;
    } mix_beat_t;

    // one output beat
    typedef struct {
        logic [SMP_W-1:0] sample;
        logic             clip;
    } mix_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SMP_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;

    // mixed samples predicted but not yet seen on the output
    mix_out_t pending_mix[$];
    int       mismatch_count = 0;
    // input beats accepted so far, fill writes included
    int       beats_sent = 0;

    // traffic shaping, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_request  = 1'b0;

    // model state of the mixer
    logic signed [SMP_W-1:0] sample_mem [SAMPLE_WORDS];
    bit                      word_written [SAMPLE_WORDS];
    bit                      voice_live [VOICE_COUNT];
    logic [ADDR_W-1:0]       voice_addr0 [VOICE_COUNT];
    logic [POS_W-1:0]        voice_pos [VOICE_COUNT];
    logic [POS_W-1:0]        voice_len [VOICE_COUNT];
    logic [VOL_W-1:0]        voice_vol [VOICE_COUNT];
    logic                    mute_q = 1'b0;

    polyphonic_sample_voice_mixer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // mixer model: advances the voices and memory for one accepted beat and
    // queues the mixed sample a produce beat must give
    // ------------------------------------------------------------------------
    function automatic void mixer_step(input mix_beat_t b);
        longint            acc;
        longint            raw;
        longint            mag;
        longint            y;
        longint            fs;
        logic [ADDR_W-1:0] rd;
        logic [POS_W-1:0]  best;
        int                slot;
        mix_out_t          r;

        fs = FULL_SCALE;
        case (b.kind)
            KIND_WRITE:
            begin
                sample_mem[b.waddr]   = b.value;
                word_written[b.waddr] = 1'b1;
            end
            KIND_START:
            begin
                // zero length claims nothing
                if (b.sound_len != 0)
                begin
                    slot = -1;
                    best = '0;
                    // first idle voice, else the furthest along, highest index on a tie
                    for (int v = 0; v < VOICE_COUNT; v++)
                    begin
                        if (!voice_live[v])
                        begin
                            slot = v;
                            break;
                        end
                        if (slot < 0 || voice_pos[v] >= best)
                        begin
                            best = voice_pos[v];
                            slot = v;
                        end
                    end
                    voice_live[slot]  = 1'b1;
                    voice_addr0[slot] = b.sound_start;
                    voice_pos[slot]   = '0;
                    voice_len[slot]   = (b.sound_len > POS_W'(SAMPLE_WORDS)) ?
                                        POS_W'(SAMPLE_WORDS) : b.sound_len;
                    voice_vol[slot]   = (b.volume > VOL_W'(UNITY_GAIN)) ?
                                        VOL_W'(UNITY_GAIN) : b.volume;
                end
            end
            KIND_PRODUCE:
            begin
                r.sample = '0;
                r.clip   = 1'b0;
                // muted: silent beat, voices hold their place
                if (!mute_q)
                begin
                    acc = 0;
                    for (int v = 0; v < VOICE_COUNT; v++)
                    begin
                        if (voice_live[v])
                        begin
                            rd  = ADDR_W'(voice_addr0[v] + voice_pos[v]);
                            acc += longint'(voice_vol[v]) * longint'(sample_mem[rd]);
                            voice_pos[v]++;
                            if (voice_pos[v] >= voice_len[v])
                                voice_live[v] = 1'b0;
                        end
                    end
                    // floor of acc / 256
                    raw = acc >>> 8;
                    if (raw > fs)
                    begin
                        y      = fs - ((raw - fs) * fs) / (10 * raw);
                        r.clip = 1'b1;
                    end
                    else if (raw < -fs)
                    begin
                        mag    = -raw;
                        y      = -(fs - ((mag - fs) * fs) / (10 * mag));
                        r.clip = 1'b1;
                    end
                    else
                    begin
                        y = raw;
                    end
                    if (y > OUT_MAX)
                        y = OUT_MAX;
                    if (y < OUT_MIN)
                        y = OUT_MIN;
                    r.sample = y[SMP_W-1:0];
                end
                pending_mix.insert(pending_mix.size(), r);
            end
            default:
            begin
                // unknown kind is dropped
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // sender: offers one beat, waits for the handshake, then updates the model;
    // valid drops only for random source idling or a settle, so beats otherwise run gapless
    // ------------------------------------------------------------------------
    task automatic send_beat(input mix_beat_t b);
        logic [IN_DATA_W-1:0] word;

        word = '0;
        word[WADDR_LSB +: WADDR_W] = b.waddr;
        word[SMP_LSB   +: SMP_W]   = b.value;
        word[START_LSB +: START_W] = b.sound_start;
        word[LEN_LSB   +: LEN_W]   = b.sound_len;
        word[VOL_LSB   +: VOL_W]   = b.volume;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= b.kind;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        beats_sent++;
        mixer_step(b);
    endtask

    // memory words are only defined once written, so before a live produce
    // every word a busy voice is about to read gets filled in first
    task automatic send_produce(input mix_beat_t b);
        logic [ADDR_W-1:0] rd;
        mix_beat_t         w;

        if (!mute_q)
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                rd = ADDR_W'(voice_addr0[v] + voice_pos[v]);
                if (voice_live[v] && !word_written[rd])
                begin
                    w       = random_beat();
                    w.kind  = KIND_WRITE;
                    w.waddr = rd;
                    send_beat(w);
                end
            end
        end
        b.kind = KIND_PRODUCE;
        send_beat(b);
    endtask

    task automatic put_write(input int addr, input int val);
        mix_beat_t b;

        b       = '{default: '0};
        b.kind  = KIND_WRITE;
        b.waddr = WADDR_W'(addr);
        b.value = SMP_W'(val);
        send_beat(b);
    endtask

    task automatic put_start(input int addr, input int len, input int vol);
        mix_beat_t b;

        b             = '{default: '0};
        b.kind        = KIND_START;
        b.sound_start = START_W'(addr);
        b.sound_len   = LEN_W'(len);
        b.volume      = VOL_W'(vol);
        send_beat(b);
    endtask

    task automatic put_produce();
        mix_beat_t b;

        b = '{default: '0};
        send_produce(b);
    endtask

    // drop valid, wait for every predicted sample, then let a start finish
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_mix.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mute(input logic value);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mute_q = value;
    endtask

    // random beat: weighted kind, every other field random at full width, then shaped per field
    function automatic mix_beat_t random_beat();
        mix_beat_t b;
        int        pick;

        b.waddr       = WADDR_W'($urandom());
        b.value       = SMP_W'($urandom());
        b.sound_start = START_W'($urandom());
        b.sound_len   = LEN_W'($urandom());
        b.volume      = VOL_W'($urandom());
        pick = $urandom_range(99);
        if (pick < 22)
            b.kind = KIND_WRITE;
        else if (pick < 42)
            b.kind = KIND_START;
        else if (pick < 95)
            b.kind = KIND_PRODUCE;
        else
            b.kind = KIND_UNKNOWN;

        // most traffic stays in a small hot region so sounds replay written data
        if ($urandom_range(9) < 7)
            b.waddr = WADDR_W'($urandom_range(HOT_WORDS - 1));
        if ($urandom_range(9) < 7)
            b.sound_start = START_W'($urandom_range(HOT_WORDS - 1));

        // near full scale often enough to drive the soft clip
        case ($urandom_range(3))
            0: b.value = 16'h7FFF - SMP_W'($urandom_range(255));
            1: b.value = 16'h8000 + SMP_W'($urandom_range(255));
            default: ;
        endcase

        pick = $urandom_range(99);
        if (pick < 70)
            b.sound_len = LEN_W'($urandom_range(48, 1));
        else if (pick < 90)
            b.sound_len = LEN_W'($urandom_range(600, 49));
        else if (pick < 95)
            b.sound_len = '0;
        else
            b.sound_len = LEN_W'($urandom_range(32767, 16000));

        pick = $urandom_range(99);
        if (pick < 60)
            b.volume = VOL_W'(UNITY_GAIN);
        else if (pick < 90)
            b.volume = VOL_W'($urandom_range(UNITY_GAIN));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random ready, or a long hold-off when the test asks for one
    // ------------------------------------------------------------------------
    initial
    begin : sink_drive
        int held;

        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // output checker: every accepted beat against the oldest prediction
    initial
    begin : result_check
        mix_out_t want;

        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_mix.size() == 0)
                begin
                    report_mismatch("output beat with no sample pending");
                end
                else
                begin
                    want = pending_mix.pop_front();
                    if (m_tdata !== want.sample)
                        report_mismatch($sformatf("mixed_sample %0d, want %0d",
                                        $signed(m_tdata), $signed(want.sample)));
                    if (m_tuser !== want.clip)
                        report_mismatch($sformatf("clipped %b, want %b",
                                        m_tuser, want.clip));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // raw exactly at full scale, one above it, and a deep negative overload
    task automatic test_soft_clip();
        put_write(0, 16384);
        put_write(1, 16385);
        put_write(2, -32768);
        put_start(0, 1, 256);
        put_start(0, 1, 256);
        put_produce();
        put_start(0, 1, 256);
        put_start(1, 1, 256);
        put_produce();
        put_start(2, 1, 256);
        put_start(2, 1, 256);
        put_produce();
    endtask

    // field extremes: top address with wrap, oversize length and gain,
    // zero length, unknown kind with every bit set
    task automatic test_field_extremes();
        mix_beat_t b;

        put_write(16383, 32767);
        put_start(16383, 2, 511);
        put_start(7, 0, 256);
        put_start(3, 32767, 300);
        b      = '{default: '1};
        b.kind = KIND_UNKNOWN;
        send_beat(b);
        put_produce();
        put_produce();
    endtask

    // one start per voice, then a produce; a start with every voice busy steals the furthest along
    task automatic test_voice_stealing();
        for (int n = 0; n < VOICE_COUNT; n++)
            put_start(n, 4, 128 + 16 * n);
        put_produce();
    endtask

    task automatic test_mute();
        mix_beat_t b;

        write_mute(1'b1);
        for (int n = 0; n < 40; n++)
        begin
            b = random_beat();
            if (b.kind == KIND_PRODUCE)
                send_produce(b);
            else
                send_beat(b);
        end
        write_mute(1'b0);
    endtask

    // beat budget counts the fill writes too
    task automatic test_random_traffic(input int beats, input int idle_pct,
                                       input int stall_pct);
        mix_beat_t b;
        int        first;

        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        first         = beats_sent;
        while (beats_sent - first < beats)
        begin
            b = random_beat();
            if (b.kind == KIND_PRODUCE)
                send_produce(b);
            else
                send_beat(b);
        end
    endtask

    // receiver holds off while produce beats keep coming, so the output
    // register and the mixer back up and the input stalls
    task automatic test_output_backpressure();
        mix_beat_t b;

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_request  = 1'b1;
        for (int n = 0; n < 20; n++)
        begin
            b = random_beat();
            send_produce(b);
        end
    endtask

    initial
    begin : run_tests
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_WRITE;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_soft_clip();
        test_field_extremes();
        test_voice_stealing();
        test_mute();
        test_random_traffic(220, 0, 0);
        test_random_traffic(220, 58, 0);
        test_random_traffic(220, 0, 58);
        test_random_traffic(220, 18, 18);
        test_output_backpressure();

        settle_block();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
